[rtl/sha1_pkg.sv]
package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV_WORDS [5] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  localparam word_t K_GROUP0 = 32'h5a82_7999;
  localparam word_t K_GROUP1 = 32'h6ed9_eba1;
  localparam word_t K_GROUP2 = 32'h8f1b_bcdc;
  localparam word_t K_GROUP3 = 32'hca62_c1d6;

  localparam word_t PAD_WORD    = 32'h8000_0000;
  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [3:0] WORDS_LAST = 4'd15;
  localparam logic [3:0] WORDS_LEN  = 4'd14;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_PAD80 = 9'b0_0000_0010,
    S_PADZ  = 9'b0_0000_0100,
    S_LENHI = 9'b0_0000_1000,
    S_LENLO = 9'b0_0001_0000,
    S_LOAD  = 9'b0_0010_0000,
    S_ROUND = 9'b0_0100_0000,
    S_ADD   = 9'b0_1000_0000,
    S_OUT   = 9'b1_0000_0000
  } state_t;

  typedef struct packed {
    logic absorb;
    logic pad80;
    logic padz;
    logic len_hi;
    logic len_lo;
    logic load;
    logic round;
    logic add;
    logic out_shift;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic fills;
    logic pad_done;
    logic round_last;
  } sts_t;

  function automatic word_t byte_mask(input logic [2:0] n);
    word_t m;
    case (n)
      3'd0: m = 32'h0000_0000;
      3'd1: m = 32'hff00_0000;
      3'd2: m = 32'hffff_0000;
      3'd3: m = 32'hffff_ff00;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

[rtl/sha1_hash_core.sv]
// sha-1 hash core, one 32-bit message word per transfer
// input channel: in_message_word holds up to four bytes, earliest in bits 31:24;
//   in_valid_bytes gives how many leading bytes count (above four means four);
//   in_last_word marks the final word of a message and starts padding
// output channel: five transfers per message, digest words h0 to h4,
//   out_digest_end set on the fifth
// bytes are packed into a 16-word schedule shift register; each full block
//   holds in_stall high through load, 80 rounds at one per cycle, and add
// input is taken only while idle and stalls during each compression, so the
//   sustained input rate is set by the single-round compression datapath
// after the last word: padding (0x80, zeros, length), one or two compressions,
//   then the digest appears, one word per cycle while out_stall is low
// a stalled digest word holds; no new input is taken until all five are out
// reset (rst_n low, synchronous) loads the initial hash value and clears
//   the length counter, the byte packer and the state machine
module sha1_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_end
);
  import sha1_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_word   (in_last_word),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_end (out_digest_end),
    .cmd            (cmd),
    .sts            (sts)
  );

  sha1_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .cmd             (cmd),
    .sts             (sts),
    .out_digest_word (out_digest_word)
  );

endmodule

[rtl/sha1_ctrl.sv]
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last_word,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_digest_end,
  output sha1_pkg::cmd_t  cmd,
  input  sha1_pkg::sts_t  sts
);
  import sha1_pkg::*;

  state_t     st_r, st_nxt;
  state_t     ret_r, ret_nxt;
  logic [2:0] ocnt_r, ocnt_nxt;

  always_comb begin
    cmd      = '0;
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    ocnt_nxt = ocnt_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.absorb = 1'b1;
          if (sts.fills) begin
            st_nxt  = S_LOAD;
            ret_nxt = in_last_word ? S_PAD80 : S_IDLE;
          end else if (in_last_word) begin
            st_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.pad80 = 1'b1;
        if (sts.fills) begin
          st_nxt  = S_LOAD;
          ret_nxt = S_PADZ;
        end else begin
          st_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.pad_done) begin
          st_nxt = S_LENHI;
        end else begin
          cmd.padz = 1'b1;
          if (sts.fills) begin
            st_nxt  = S_LOAD;
            ret_nxt = S_PADZ;
          end
        end
      end
      S_LENHI: begin
        cmd.len_hi = 1'b1;
        st_nxt     = S_LENLO;
      end
      S_LENLO: begin
        cmd.len_lo = 1'b1;
        st_nxt     = S_LOAD;
        ret_nxt    = S_OUT;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        st_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) begin
          st_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add  = 1'b1;
        st_nxt   = ret_r;
        ocnt_nxt = 3'd0;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (ocnt_r == 3'd4) begin
            cmd.out_last = 1'b1;
            st_nxt       = S_IDLE;
          end else begin
            cmd.out_shift = 1'b1;
            ocnt_nxt      = ocnt_r + 3'd1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      ocnt_r <= 3'd0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  assign in_stall       = (st_r != S_IDLE);
  assign out_valid      = (st_r == S_OUT);
  assign out_digest_end = (ocnt_r == 3'd4);

`ifndef SYNTH
  a_add_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ADD) |=> (st_r == $past(ret_r)))
    else $error("compression did not return to saved state");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && out_stall) |=> (st_r == S_OUT && $stable(ocnt_r)))
    else $error("digest index moved while stalled");
`endif

endmodule

[rtl/sha1_dp.sv]
module sha1_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     in_message_word,
  input  logic [2:0]      in_valid_bytes,
  input  sha1_pkg::cmd_t  cmd,
  output sha1_pkg::sts_t  sts,
  output logic [31:0]     out_digest_word
);
  import sha1_pkg::*;

  word_t       chain_r [5];
  word_t       w_r [16];
  word_t       wv_r [5];
  word_t       stage_r;
  logic [1:0]  k_r;
  logic [3:0]  wcnt_r;
  logic [63:0] bits_r;
  logic [6:0]  rnd_r;

  word_t       pk_word;
  logic [2:0]  pk_cnt;
  logic        pk_en;
  logic [63:0] comb64;
  logic [2:0]  tot;
  logic        push;
  word_t       w_new;
  word_t       f_val;
  word_t       k_val;
  word_t       tmp;

  // byte packer
  always_comb begin
    pk_word = '0;
    pk_cnt  = 3'd0;
    if (cmd.absorb) begin
      pk_word = in_message_word;
      pk_cnt  = (in_valid_bytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES : in_valid_bytes;
    end else if (cmd.pad80) begin
      pk_word = PAD_WORD;
      pk_cnt  = 3'd1;
    end else if (cmd.padz) begin
      pk_cnt = FULL_WORD_BYTES - {1'b0, k_r};
    end else if (cmd.len_hi) begin
      pk_word = bits_r[63:32];
      pk_cnt  = FULL_WORD_BYTES;
    end else if (cmd.len_lo) begin
      pk_word = bits_r[31:0];
      pk_cnt  = FULL_WORD_BYTES;
    end
  end

  assign pk_en  = cmd.absorb | cmd.pad80 | cmd.padz | cmd.len_hi | cmd.len_lo;
  assign comb64 = {stage_r & byte_mask({1'b0, k_r}), 32'h0}
                | ({pk_word & byte_mask(pk_cnt), 32'h0} >> {k_r, 3'b000});
  assign tot    = {1'b0, k_r} + pk_cnt;
  assign push   = pk_en & tot[2];

  assign sts.fills      = push && (wcnt_r == WORDS_LAST);
  assign sts.pad_done   = (wcnt_r == WORDS_LEN) && (k_r == 2'd0);
  assign sts.round_last = (rnd_r == ROUND_LAST);

  // round logic
  always_comb begin
    word_t x;
    x = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = (rnd_r < 7'd16) ? w_r[0] : {x[30:0], x[31]};
    if (rnd_r < 7'd20) begin
      f_val = (wv_r[1] & wv_r[2]) | (~wv_r[1] & wv_r[3]);
      k_val = K_GROUP0;
    end else if (rnd_r < 7'd40) begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K_GROUP1;
    end else if (rnd_r < 7'd60) begin
      f_val = (wv_r[1] & wv_r[2]) | (wv_r[1] & wv_r[3]) | (wv_r[2] & wv_r[3]);
      k_val = K_GROUP2;
    end else begin
      f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_val = K_GROUP3;
    end
    tmp = {wv_r[0][26:0], wv_r[0][31:27]} + f_val + wv_r[4] + k_val + w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= IV_WORDS[i];
      end
      k_r    <= 2'd0;
      wcnt_r <= 4'd0;
      bits_r <= 64'd0;
      rnd_r  <= 7'd0;
    end else begin
      if (pk_en) begin
        k_r <= tot[1:0];
      end
      if (push) begin
        wcnt_r <= wcnt_r + 4'd1;
      end
      if (cmd.absorb) begin
        bits_r <= bits_r + 64'({pk_cnt, 3'b000});
      end else if (cmd.out_last) begin
        bits_r <= 64'd0;
      end
      if (cmd.load) begin
        rnd_r <= 7'd0;
      end else if (cmd.round) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.add) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end else if (cmd.out_shift) begin
        for (int i = 0; i < 4; i++) begin
          chain_r[i] <= chain_r[i + 1];
        end
        chain_r[4] <= chain_r[0];
      end else if (cmd.out_last) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= IV_WORDS[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pk_en) begin
      stage_r <= push ? comb64[31:0] : comb64[63:32];
    end
    if (push || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= push ? comb64[63:32] : w_new;
    end
    if (cmd.load) begin
      for (int i = 0; i < 5; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      wv_r[0] <= tmp;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= {wv_r[1][1:0], wv_r[1][31:2]};
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3];
    end
  end

  assign out_digest_word = chain_r[0];

`ifndef SYNTH
  a_load_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (wcnt_r == 4'd0))
    else $error("compression started on a partial block");

  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.round && !sts.round_last) |=> (rnd_r == $past(rnd_r) + 7'd1))
    else $error("round counter skipped");

  a_msg_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_last |=> (bits_r == 64'd0 && k_r == 2'd0 && chain_r[0] == IV_WORDS[0]))
    else $error("message state not cleared after digest");
`endif

endmodule

[dv/sha1_hash_core_tb.sv]
module sha1_hash_core_tb;
  import sha1_pkg::word_t;

  localparam logic [159:0] H_INIT =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;
  localparam word_t K_R00 = 32'h5a82_7999;
  localparam word_t K_R20 = 32'h6ed9_eba1;
  localparam word_t K_R40 = 32'h8f1b_bcdc;
  localparam word_t K_R60 = 32'hca62_c1d6;

  localparam int RAND_WORDS     = 420;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DIR_ROWS       = 15;

  typedef struct packed {
    word_t        word;
    logic [2:0]   nbytes;
    logic         last;
    logic         known;
    logic [159:0] digest;
  } dir_row_t;

  typedef struct packed {
    word_t word;
    logic  dend;
  } digest_beat_t;

  // empty message and "abc" digests are typed in, the rest come from the predictor
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{32'hffff_ffff, 3'd0, 1'b1, 1'b1,
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
    '{32'h6162_63ff, 3'd3, 1'b1, 1'b1,
      160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, 160'h0},
    '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, 160'h0},
    '{32'h1234_5678, 3'd1, 1'b0, 1'b0, 160'h0},
    '{32'h9abc_def0, 3'd7, 1'b0, 1'b0, 160'h0},
    '{32'h0fed_cba9, 3'd5, 1'b0, 1'b0, 160'h0},
    '{32'h5555_5555, 3'd2, 1'b0, 1'b0, 160'h0},
    '{32'haaaa_aaaa, 3'd6, 1'b1, 1'b0, 160'h0},
    '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 160'h0},
    '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 160'h0},
    '{32'h8000_0000, 3'd1, 1'b1, 1'b0, 160'h0},
    '{32'h0102_0304, 3'd0, 1'b0, 1'b0, 160'h0},
    '{32'ha5a5_a5a5, 3'd3, 1'b1, 1'b0, 160'h0},
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1,
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_message_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic        out_digest_end;

  sha1_hash_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_end  (out_digest_end)
  );

  always #1 clk = ~clk;

  word_t        chain_h [5];
  word_t        block_w [16];
  logic [5:0]   fill_pos;
  logic [63:0]  bit_len;
  word_t        digest_h [5];
  digest_beat_t digest_q [$];
  digest_beat_t beat;
  int           words_in = 0;
  int           results_seen = 0;
  int           fails = 0;
  int           quiet = 0;
  int           k_i;

  function automatic void sha_restart();
    int i;
    for (i = 0; i < 5; i++) chain_h[i] = H_INIT[159 - 32 * i -: 32];
    fill_pos = '0;
    bit_len = '0;
  endfunction

  function automatic void sha_compress();
    word_t w [16];
    word_t a, b, c, d, e, f, k, t, x;
    int r;
    for (r = 0; r < 16; r++) w[r] = block_w[r];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
        x = {x[30:0], x[31]};
        w[r % 16] = x;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R00;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R20;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R40;
      end else begin
        f = b ^ c ^ d;
        k = K_R60;
      end
      t = {a[26:0], a[31:27]} + f + e + k + x;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha_put_byte(input logic [7:0] b);
    block_w[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
    if (fill_pos == 6'd63) begin
      sha_compress();
      fill_pos = '0;
    end else begin
      fill_pos = fill_pos + 6'd1;
    end
  endfunction

  // returns 1 when the word closes a message and digest_h holds the hash
  function automatic bit sha_absorb(input word_t w, input logic [2:0] nb, input logic lw);
    int n, i;
    logic [63:0] len;
    n = (nb > 3'd4) ? 4 : int'(nb);
    for (i = 0; i < n; i++) begin
      sha_put_byte(w[31 - 8 * i -: 8]);
      bit_len += 64'd8;
    end
    if (!lw) return 1'b0;
    len = bit_len;
    sha_put_byte(8'h80);
    while (fill_pos != 6'd56) sha_put_byte(8'h00);
    for (i = 0; i < 8; i++) sha_put_byte(len[63 - 8 * i -: 8]);
    for (i = 0; i < 5; i++) digest_h[i] = chain_h[i];
    sha_restart();
    return 1'b1;
  endfunction

  initial begin
    sha_restart();
    for (k_i = 0; k_i < 16; k_i++) block_w[k_i] = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (sha_absorb(in_message_word, in_valid_bytes, in_last_word)) begin
          if (words_in < DIR_ROWS && DIR_TAB[words_in].known) begin
            for (k_i = 0; k_i < 5; k_i++)
              digest_h[k_i] = DIR_TAB[words_in].digest[159 - 32 * k_i -: 32];
          end
          for (k_i = 0; k_i < 5; k_i++)
            digest_q.push_back('{digest_h[k_i], k_i == 4});
        end
        words_in++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest transfer: digest_word %h digest_end %b",
                 out_digest_word, out_digest_end);
          fails++;
        end else begin
          beat = digest_q.pop_front();
          if (out_digest_word !== beat.word) begin
            $error("digest_word: expected %h, actual %h", beat.word, out_digest_word);
            fails++;
          end
          if (out_digest_end !== beat.dend) begin
            $error("digest_end: expected %b, actual %b", beat.dend, out_digest_end);
            fails++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: short and long stalls, stall-free stretches, one long hold-off
  initial begin : rx_side
    int r;
    bit held;
    held = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (r < 45) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic put_word(input word_t w, input logic [2:0] nb, input logic lw, input int gap);
    in_valid <= 1'b1;
    in_message_word <= w;
    in_valid_bytes <= nb;
    in_last_word <= lw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_digests_out();
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  initial begin : tx_side
    int i, nw, r, gap, sent;
    bit burst, pause;
    logic [2:0] nb;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      put_word(DIR_TAB[i].word, DIR_TAB[i].nbytes, DIR_TAB[i].last,
               (i == DIR_ROWS - 1) ? 1 : pick_gap());
    wait_digests_out();

    sent = 0;
    while (sent < RAND_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 50) nw = $urandom_range(1, 8);
      else if (r < 80) nw = $urandom_range(12, 18);
      else if (r < 95) nw = $urandom_range(28, 34);
      else nw = $urandom_range(60, 70);
      burst = ($urandom_range(0, 3) == 0);
      pause = ($urandom_range(0, 9) == 0);
      for (i = 0; i < nw; i++) begin
        if (i == nw - 1 || $urandom_range(0, 99) >= 85) nb = 3'($urandom_range(0, 7));
        else nb = 3'd4;
        gap = burst ? 0 : pick_gap();
        if (i == nw - 1 && pause && gap == 0) gap = 1;
        put_word($urandom, nb, i == nw - 1, gap);
        sent++;
      end
      if (pause) wait_digests_out();
    end
    in_valid <= 1'b0;

    wait_digests_out();
    repeat (300) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/sha1_pkg.sv
rtl/sha1_ctrl.sv
rtl/sha1_dp.sv
rtl/sha1_hash_core.sv
dv/sha1_hash_core_tb.sv
